[hdl/cxyz_pkg.sv]
package cxyz_pkg;

    localparam int POS_W = 16;
    localparam int ZPOS_W = 15;
    localparam int ZDLY_W = 7;
    localparam int RATE_W = 9;
    localparam int ERR_W = 10;
    localparam int CNT_W = 5;
    localparam int VEL_W = 8;
    localparam int IDX_W = 8;

    // delay table depth; the speed index is clamped to its last entry
    localparam int DELAY_ENTRIES = 100;
    localparam int RELOAD_BASE = 20;
    // x/5 == (x*205)>>10 for any 8-bit x
    localparam int DIV5_MUL = 205;
    localparam int DIV5_SHIFT = 10;

    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 56;
    localparam int ADDR_W = 5;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic [ZPOS_W-1:0] zpos_t;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_VEL  = 2'd1,
        CMD_ZTGT = 2'd2
    } cmd_e;

    typedef enum logic [2:0] {
        REG_X_MIN   = 3'd0,
        REG_X_MAX   = 3'd1,
        REG_Y_MIN   = 3'd2,
        REG_Y_MAX   = 3'd3,
        REG_Z_MIN   = 3'd4,
        REG_Z_MAX   = 3'd5,
        REG_Z_DELAY = 3'd6
    } reg_idx_e;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic [IDX_W-1:0]        speed_index;
        logic signed [15:0]      z_goal;
    } item_t;

    typedef struct packed {
        pos_t              x_min;
        pos_t              x_max;
        pos_t              y_min;
        pos_t              y_max;
        zpos_t             z_min;
        zpos_t             z_max;
        logic [ZDLY_W-1:0] z_delay;
    } cfg_t;

    typedef struct packed {
        logic step_a;
        logic step_b;
        logic dir_a;
        logic dir_b;
        pos_t x_pos;
        pos_t y_pos;
    } xy_res_t;

    typedef struct packed {
        logic  step_z;
        logic  dir_z;
        zpos_t z_pos;
        logic  busy;
        logic  accepted;
    } z_res_t;

    typedef struct packed {
        logic ok;
        pos_t x;
        pos_t y;
    } move_t;

    // one motor step: motor a moves (s,s), motor b moves (s,-s); refused outside the box
    function automatic move_t try_move(pos_t px, pos_t py, logic neg, logic is_b, cfg_t cfg);
        logic signed [POS_W:0] one;
        logic signed [POS_W:0] mone;
        logic signed [POS_W:0] nx;
        logic signed [POS_W:0] ny;
        move_t m;
        one = (POS_W+1)'(1);
        mone = '1;
        nx = {px[POS_W-1], px} + (neg ? mone : one);
        ny = {py[POS_W-1], py} + ((neg ^ is_b) ? mone : one);
        m.ok = (nx >= $signed({cfg.x_min[POS_W-1], cfg.x_min}))
            && (nx <= $signed({cfg.x_max[POS_W-1], cfg.x_max}))
            && (ny >= $signed({cfg.y_min[POS_W-1], cfg.y_min}))
            && (ny <= $signed({cfg.y_max[POS_W-1], cfg.y_max}));
        m.x = nx[POS_W-1:0];
        m.y = ny[POS_W-1:0];
        return m;
    endfunction

endpackage

[hdl/cxyz_xy_stepper.sv]
module cxyz_xy_stepper (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  cxyz_pkg::item_t   item,
    input  cxyz_pkg::cfg_t    cfg,
    output cxyz_pkg::xy_res_t res
);
    import cxyz_pkg::*;

    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DELAY_ENTRIES - 1);

    pos_t              pos_x_reg, pos_x_next;
    pos_t              pos_y_reg, pos_y_next;
    logic              en_a_reg, en_a_next;
    logic              en_b_reg, en_b_next;
    logic              neg_a_reg, neg_a_next;
    logic              neg_b_reg, neg_b_next;
    logic [RATE_W-1:0] rate_a_reg, rate_a_next;
    logic [RATE_W-1:0] rate_b_reg, rate_b_next;
    logic [ERR_W-1:0]  err_a_reg, err_a_next;
    logic [ERR_W-1:0]  err_b_reg, err_b_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  reload_reg, reload_next;
    logic              dir_a_reg, dir_a_next;
    logic              dir_b_reg, dir_b_next;

    logic                     fire;
    logic                     a_first;
    move_t                    m1, m2;
    logic                     step_first, step_second, second_due;
    pos_t                     p1_x, p1_y;
    logic [ERR_W-1:0]         err_sum, err_new;
    logic [ERR_W-1:0]         rate_first;
    logic signed [RATE_W-1:0] va, vb;
    logic [IDX_W-1:0]         idx;
    logic [2*IDX_W-1:0]       prod;
    logic [IDX_W-DIV5_SHIFT+IDX_W-1:0] quot;
    logic [CNT_W:0]           diff;
    logic [CNT_W-1:0]         reload_calc;

    always_comb begin
        // bresenham step: faster motor first, slower one from the updated position
        fire = cnt_reg <= CNT_W'(1);
        a_first = rate_a_reg >= rate_b_reg;
        m1 = try_move(pos_x_reg, pos_y_reg, a_first ? neg_a_reg : neg_b_reg, !a_first, cfg);
        step_first = (a_first ? en_a_reg : en_b_reg) && m1.ok;
        p1_x = step_first ? m1.x : pos_x_reg;
        p1_y = step_first ? m1.y : pos_y_reg;
        err_sum = (a_first ? err_a_reg : err_b_reg)
            + ERR_W'(a_first ? rate_b_reg : rate_a_reg);
        rate_first = ERR_W'(a_first ? rate_a_reg : rate_b_reg);
        second_due = err_sum >= rate_first;
        err_new = second_due ? err_sum - rate_first : err_sum;
        m2 = try_move(p1_x, p1_y, a_first ? neg_b_reg : neg_a_reg, a_first, cfg);
        step_second = second_due && (a_first ? en_b_reg : en_a_reg) && m2.ok;

        va = RATE_W'(item.vel_x) + RATE_W'(item.vel_y);
        vb = RATE_W'(item.vel_x) - RATE_W'(item.vel_y);
        idx = (item.speed_index > IDX_MAX) ? IDX_MAX : item.speed_index;
        prod = (2*IDX_W)'(idx) * (2*IDX_W)'(DIV5_MUL);
        quot = prod[2*IDX_W-1:DIV5_SHIFT];
        diff = (CNT_W+1)'(RELOAD_BASE) - (CNT_W+1)'(quot);
        reload_calc = (quot >= ($bits(quot))'(RELOAD_BASE)) ? CNT_W'(1) : diff[CNT_W-1:0];

        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        en_a_next = en_a_reg;
        en_b_next = en_b_reg;
        neg_a_next = neg_a_reg;
        neg_b_next = neg_b_reg;
        rate_a_next = rate_a_reg;
        rate_b_next = rate_b_reg;
        err_a_next = err_a_reg;
        err_b_next = err_b_reg;
        cnt_next = cnt_reg;
        reload_next = reload_reg;
        dir_a_next = dir_a_reg;
        dir_b_next = dir_b_reg;
        res.step_a = 1'b0;
        res.step_b = 1'b0;

        case (item.command)
            CMD_TICK: begin
                if (fire) begin
                    res.step_a = a_first ? step_first : step_second;
                    res.step_b = a_first ? step_second : step_first;
                    pos_x_next = step_second ? m2.x : p1_x;
                    pos_y_next = step_second ? m2.y : p1_y;
                    if (a_first) begin
                        err_a_next = err_new;
                    end else begin
                        err_b_next = err_new;
                    end
                    cnt_next = reload_reg;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            CMD_VEL: begin
                if (item.vel_x == '0 && item.vel_y == '0) begin
                    rate_a_next = '0;
                    rate_b_next = '0;
                    en_a_next = 1'b0;
                    en_b_next = 1'b0;
                    neg_a_next = 1'b0;
                    neg_b_next = 1'b0;
                end else begin
                    en_a_next = 1'b1;
                    en_b_next = 1'b1;
                    neg_a_next = va[RATE_W-1];
                    neg_b_next = vb[RATE_W-1];
                    // magnitude of -256 wraps to 256 when read unsigned
                    rate_a_next = va[RATE_W-1] ? RATE_W'(-va) : RATE_W'(va);
                    rate_b_next = vb[RATE_W-1] ? RATE_W'(-vb) : RATE_W'(vb);
                    err_a_next = '0;
                    err_b_next = '0;
                    dir_a_next = !va[RATE_W-1];
                    dir_b_next = !vb[RATE_W-1];
                    reload_next = reload_calc;
                end
            end
            default: begin
            end
        endcase

        res.dir_a = dir_a_next;
        res.dir_b = dir_b_next;
        res.x_pos = pos_x_next;
        res.y_pos = pos_y_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            en_a_reg <= 1'b0;
            en_b_reg <= 1'b0;
            neg_a_reg <= 1'b0;
            neg_b_reg <= 1'b0;
            rate_a_reg <= '0;
            rate_b_reg <= '0;
            err_a_reg <= '0;
            err_b_reg <= '0;
            cnt_reg <= '0;
            reload_reg <= CNT_W'(RELOAD_BASE);
            dir_a_reg <= 1'b0;
            dir_b_reg <= 1'b0;
        end else if (advance) begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            en_a_reg <= en_a_next;
            en_b_reg <= en_b_next;
            neg_a_reg <= neg_a_next;
            neg_b_reg <= neg_b_next;
            rate_a_reg <= rate_a_next;
            rate_b_reg <= rate_b_next;
            err_a_reg <= err_a_next;
            err_b_reg <= err_b_next;
            cnt_reg <= cnt_next;
            reload_reg <= reload_next;
            dir_a_reg <= dir_a_next;
            dir_b_reg <= dir_b_next;
        end
    end

endmodule

[hdl/cxyz_z_axis.sv]
module cxyz_z_axis (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  cxyz_pkg::item_t  item,
    input  cxyz_pkg::cfg_t   cfg,
    output cxyz_pkg::z_res_t res
);
    import cxyz_pkg::*;

    zpos_t             pos_reg, pos_next;
    zpos_t             left_reg, left_next;
    logic              up_reg, up_next;
    logic [ZDLY_W-1:0] cd_reg, cd_next;
    logic              active_reg, active_next;
    logic              dir_reg, dir_next;

    zpos_t             t_raw, t_clamp;
    logic              up_move;
    logic [ZDLY_W-1:0] cd_dec;

    always_comb begin
        t_raw = item.z_goal[ZPOS_W-1:0];
        // low bound is checked first; when the bounds cross, a target below z_min takes z_min and any other takes z_max
        if (t_raw < cfg.z_min) begin
            t_clamp = cfg.z_min;
        end else if (t_raw > cfg.z_max) begin
            t_clamp = cfg.z_max;
        end else begin
            t_clamp = t_raw;
        end
        up_move = t_clamp > pos_reg;
        cd_dec = (cd_reg != '0) ? cd_reg - ZDLY_W'(1) : cd_reg;

        pos_next = pos_reg;
        left_next = left_reg;
        up_next = up_reg;
        cd_next = cd_reg;
        active_next = active_reg;
        dir_next = dir_reg;
        res.step_z = 1'b0;
        res.accepted = 1'b0;

        case (item.command)
            CMD_TICK: begin
                cd_next = cd_dec;
                if (cd_dec == '0 && active_reg) begin
                    if (left_reg == '0) begin
                        active_next = 1'b0;
                    end else begin
                        dir_next = up_reg;
                        res.step_z = 1'b1;
                        if (up_reg) begin
                            pos_next = pos_reg + ZPOS_W'(1);
                        end else if (pos_reg != '0) begin
                            pos_next = pos_reg - ZPOS_W'(1);
                        end
                        left_next = left_reg - ZPOS_W'(1);
                        cd_next = cfg.z_delay;
                    end
                end
            end
            CMD_ZTGT: begin
                if (!active_reg && !item.z_goal[15] && t_clamp != pos_reg) begin
                    up_next = up_move;
                    left_next = up_move ? t_clamp - pos_reg : pos_reg - t_clamp;
                    active_next = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase

        res.dir_z = dir_next;
        res.z_pos = pos_next;
        res.busy = active_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            left_reg <= '0;
            up_reg <= 1'b0;
            cd_reg <= '0;
            active_reg <= 1'b0;
            dir_reg <= 1'b0;
        end else if (advance) begin
            pos_reg <= pos_next;
            left_reg <= left_next;
            up_reg <= up_next;
            cd_reg <= cd_next;
            active_reg <= active_next;
            dir_reg <= dir_next;
        end
    end

endmodule

[hdl/corexy_z_step_generator.sv]
// CoreXY step generator with a Z axis. Each transfer on the s_ side is a timer tick
// (tuser 0), a planar velocity (tuser 1) or a Z target (tuser 2); every item gives exactly
// one result transfer on the m_ side with the step pulses, pin levels and tracked
// positions after that item. An item is captured in an input register, the XY and Z
// updates are one pass of adds and compares, and the result lands in an output
// register, where it is held until the m_ side takes it. A new item is taken every cycle
// while the output side keeps up. Limits and the Z step delay must be written over the
// APB port only while the stream is idle; the block itself does not enforce this.
module corexy_z_step_generator (
    input  logic                            aclk,
    input  logic                            aresetn,
    // apb configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cxyz_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vel_x[7:0], vel_y[15:8], speed_index[23:16], z_goal[39:24]
    input  logic [cxyz_pkg::IN_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [1:0]                      s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // step_a[0], step_b[1], dir_a[2], dir_b[3], step_z[4], dir_z[5], x_position[21:6],
    // y_position[37:22], z_position[52:38], z_busy[53], z_accepted[54], zero[55]
    output logic [cxyz_pkg::OUT_DATA_W-1:0] m_tdata
);
    import cxyz_pkg::*;

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic    advance;
    logic    cfg_wr;
    xy_res_t xy_res;
    z_res_t  z_res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_min <= pos_t'(-32768);
            cfg_reg.x_max <= pos_t'(32767);
            cfg_reg.y_min <= pos_t'(-32768);
            cfg_reg.y_max <= pos_t'(32767);
            cfg_reg.z_min <= '0;
            cfg_reg.z_max <= '1;
            cfg_reg.z_delay <= ZDLY_W'(2);
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_X_MIN:   cfg_reg.x_min <= pwdata[POS_W-1:0];
                REG_X_MAX:   cfg_reg.x_max <= pwdata[POS_W-1:0];
                REG_Y_MIN:   cfg_reg.y_min <= pwdata[POS_W-1:0];
                REG_Y_MAX:   cfg_reg.y_max <= pwdata[POS_W-1:0];
                REG_Z_MIN:   cfg_reg.z_min <= pwdata[ZPOS_W-1:0];
                REG_Z_MAX:   cfg_reg.z_max <= pwdata[ZPOS_W-1:0];
                REG_Z_DELAY: cfg_reg.z_delay <= pwdata[ZDLY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_X_MIN:   prdata = 32'({16'd0, cfg_reg.x_min});
            REG_X_MAX:   prdata = 32'({16'd0, cfg_reg.x_max});
            REG_Y_MIN:   prdata = 32'({16'd0, cfg_reg.y_min});
            REG_Y_MAX:   prdata = 32'({16'd0, cfg_reg.y_max});
            REG_Z_MIN:   prdata = 32'(cfg_reg.z_min);
            REG_Z_MAX:   prdata = 32'(cfg_reg.z_max);
            REG_Z_DELAY: prdata = 32'(cfg_reg.z_delay);
            default:     prdata = '0;
        endcase
    end

    // the held item is processed when the output register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.command <= s_tuser;
            item_reg.vel_x <= s_tdata[7:0];
            item_reg.vel_y <= s_tdata[15:8];
            item_reg.speed_index <= s_tdata[23:16];
            item_reg.z_goal <= s_tdata[39:24];
        end
    end

    cxyz_xy_stepper u_xy (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (xy_res)
    );

    cxyz_z_axis u_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (z_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {1'b0, z_res.accepted, z_res.busy, z_res.z_pos,
                             xy_res.y_pos, xy_res.x_pos, z_res.dir_z, z_res.step_z,
                             xy_res.dir_b, xy_res.dir_a, xy_res.step_b, xy_res.step_a};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    a_steps_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && item_reg.command != CMD_TICK
        |-> !xy_res.step_a && !xy_res.step_b && !z_res.step_z)
        else $error("step pulse on a non-tick item");

    a_accept_sets_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && z_res.accepted |-> z_res.busy && item_reg.command == CMD_ZTGT)
        else $error("z move accepted without going busy");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed item did not reach the output register");

endmodule
